FILE: src/thumb_alu_execute_macros.svh
// Assertion helpers for the Thumb ALU execute block
`ifndef THUMB_ALU_EXECUTE_MACROS_SVH
`define THUMB_ALU_EXECUTE_MACROS_SVH
// implication checked on every clock edge outside reset
`define TAE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// implication with the consequent checked in the following cycle
`define TAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

FILE: src/tae_pkg.sv
package tae_pkg;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] CLS_ADDSUB = 3'd0;
  localparam logic [2:0] CLS_SHIMM  = 3'd1;
  localparam logic [2:0] CLS_IMM    = 3'd2;
  localparam logic [2:0] CLS_ALU    = 3'd3;
  localparam logic [2:0] CLS_BAD    = 3'd4;

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_LSL = 4'd2;
  localparam logic [3:0] OP_LSR = 4'd3;
  localparam logic [3:0] OP_ASR = 4'd4;
  localparam logic [3:0] OP_ADC = 4'd5;
  localparam logic [3:0] OP_SBC = 4'd6;
  localparam logic [3:0] OP_ROR = 4'd7;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_NEG = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_CMN = 4'd11;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MUL = 4'd13;
  localparam logic [3:0] OP_BIC = 4'd14;
  localparam logic [3:0] OP_MVN = 4'd15;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // immediate-format operations
  localparam logic [1:0] IM_MOV = 2'd0;
  localparam logic [1:0] IM_CMP = 2'd1;
  localparam logic [1:0] IM_ADD = 2'd2;
  localparam logic [1:0] IM_SUB = 2'd3;

  // decoded instruction passed from front to back
  typedef struct packed {
    logic [2:0]  cls;
    logic [15:0] ins;
  } dec_t;
endpackage

FILE: src/tae_front.sv
module tae_front #(
  parameter int unsigned QueueDepth = tae_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          ready,
  input  logic [15:0]   instruction,
  output logic          q_valid,
  input  logic          q_ready,
  output tae_pkg::dec_t q_data
);
  import tae_pkg::*;

  dec_t slot [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wr_ptr, rd_ptr;
  logic [$clog2(QueueDepth):0]   count;
  dec_t dec;
  logic push, pop;

  // classify the instruction format
  always_comb begin
    dec.ins = instruction;
    if (instruction[15:11] == 5'b00011)     dec.cls = CLS_ADDSUB;
    else if (instruction[15:13] == 3'b000)  dec.cls = CLS_SHIMM;
    else if (instruction[15:13] == 3'b001)  dec.cls = CLS_IMM;
    else if (instruction[15:10] == 6'b010000) dec.cls = CLS_ALU;
    else                                    dec.cls = CLS_BAD;
  end

  assign ready   = (count != ($clog2(QueueDepth)+1)'(QueueDepth));
  assign q_valid = (count != '0);
  assign q_data  = slot[rd_ptr];
  assign push    = valid && ready;
  assign pop     = q_valid && q_ready;

  // hold decoded beats until the back end takes them
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= dec;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (($clog2(QueueDepth)+1)'(push)) - (($clog2(QueueDepth)+1)'(pop));
    end
  end
endmodule

FILE: src/tae_back.sv
module tae_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  tae_pkg::dec_t q_data,
  output logic          valid,
  input  logic          ready,
  output logic          writes_register,
  output logic [2:0]    dest_index,
  output logic [31:0]   written_value,
  output logic [3:0]    flags_nzcv,
  output logic          unsupported
);
  import tae_pkg::*;

  logic [31:0] regs [8];
  logic [3:0]  flags;
  logic [15:0] ins;
  logic [2:0]  rd, rs, f3;
  logic [31:0] a, b, opnd, value, sh_in;
  logic [3:0]  nf;
  logic        wr, bad, cin;
  logic [32:0] sum;
  logic [31:0] add_a, add_b;
  logic        add_c, use_add, use_sh;
  logic [1:0]  sh_kind;
  logic [7:0]  sh_amt;
  logic [31:0] sh_out;
  logic        sh_c;
  logic [31:0] prod;
  logic [4:0]  n;
  logic        fire;

  assign ins     = q_data.ins;
  assign q_ready = !valid || ready;
  assign fire    = q_valid && q_ready;
  assign cin     = flags[1];
  assign f3      = ins[8:6];
  assign rs      = ins[5:3];

  // barrel shifter with ARM rules for zero and large amounts
  always_comb begin
    sh_out = sh_in;
    sh_c   = cin;
    n      = sh_amt[4:0];
    if (sh_amt != 8'd0) begin
      case (sh_kind)
        SH_LSL: begin
          if (sh_amt < 8'd32) begin
            sh_out = sh_in << sh_amt[4:0];
            sh_c   = sh_in[5'd0 - sh_amt[4:0]];
          end else begin
            sh_out = '0;
            sh_c   = (sh_amt == 8'd32) ? sh_in[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (sh_amt < 8'd32) begin
            sh_out = sh_in >> sh_amt[4:0];
            sh_c   = sh_in[sh_amt[4:0] - 5'd1];
          end else begin
            sh_out = '0;
            sh_c   = (sh_amt == 8'd32) ? sh_in[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (sh_amt < 8'd32) begin
            sh_out = 32'($signed(sh_in) >>> sh_amt[4:0]);
            sh_c   = sh_in[sh_amt[4:0] - 5'd1];
          end else begin
            sh_out = {32{sh_in[31]}};
            sh_c   = sh_in[31];
          end
        end
        default: begin
          if (n == 5'd0) begin
            sh_c = sh_in[31];
          end else begin
            sh_out = (sh_in >> n) | (sh_in << (6'd32 - {1'b0, n}));
            sh_c   = sh_in[n - 5'd1];
          end
        end
      endcase
    end
  end

  assign sum  = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
  assign prod = a * b;

  // execute one beat
  always_comb begin
    rd = ins[2:0]; a = regs[ins[2:0]]; b = regs[rs];
    opnd = ins[10] ? {29'd0, f3} : regs[f3];
    add_a = a; add_b = b; add_c = 1'b0; use_add = 1'b0; use_sh = 1'b0;
    sh_kind = SH_LSL; sh_in = a; sh_amt = b[7:0];
    value = '0; wr = 1'b1; bad = 1'b0; nf = flags;
    case (q_data.cls)
      CLS_ADDSUB: begin
        add_a = b; use_add = 1'b1;
        add_b = ins[9] ? ~opnd : opnd; add_c = ins[9];
      end
      CLS_SHIMM: begin
        use_sh = 1'b1; sh_kind = ins[12:11]; sh_in = b;
        sh_amt = (ins[12:11] != SH_LSL && ins[10:6] == 5'd0) ? 8'd32 : {3'd0, ins[10:6]};
      end
      CLS_IMM: begin
        rd = ins[10:8]; add_a = regs[ins[10:8]];
        case (ins[12:11])
          IM_MOV: begin
            value = {24'd0, ins[7:0]};
            nf = {1'b0, ins[7:0] == 8'd0, flags[1:0]};
          end
          IM_ADD: begin add_b = {24'd0, ins[7:0]}; use_add = 1'b1; end
          default: begin
            add_b = ~{24'd0, ins[7:0]}; add_c = 1'b1; use_add = 1'b1;
            wr = (ins[12:11] == IM_SUB);
          end
        endcase
      end
      CLS_ALU: begin
        case (ins[9:6])
          OP_AND: value = a & b;
          OP_EOR: value = a ^ b;
          OP_LSL: begin use_sh = 1'b1; sh_kind = SH_LSL; end
          OP_LSR: begin use_sh = 1'b1; sh_kind = SH_LSR; end
          OP_ASR: begin use_sh = 1'b1; sh_kind = SH_ASR; end
          OP_ROR: begin use_sh = 1'b1; sh_kind = SH_ROR; end
          OP_ADC: begin use_add = 1'b1; add_c = cin; end
          OP_SBC: begin use_add = 1'b1; add_b = ~b; add_c = cin; end
          OP_TST: begin value = a & b; wr = 1'b0; end
          OP_NEG: begin use_add = 1'b1; add_a = '0; add_b = ~b; add_c = 1'b1; end
          OP_CMP: begin use_add = 1'b1; add_b = ~b; add_c = 1'b1; wr = 1'b0; end
          OP_CMN: begin use_add = 1'b1; wr = 1'b0; end
          OP_ORR: value = a | b;
          OP_MUL: value = prod;
          OP_BIC: value = a & ~b;
          default: value = ~b;
        endcase
        if (!use_add && !use_sh)
          nf = {value[31], value == 32'd0, (ins[9:6] == OP_MUL) ? 1'b0 : flags[1], flags[0]};
      end
      default: begin bad = 1'b1; wr = 1'b0; end
    endcase
    if (use_add) begin
      value = sum[31:0];
      nf = {sum[31], sum[31:0] == 32'd0, sum[32],
            ((add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]))};
    end
    if (use_sh) begin
      value = sh_out;
      nf = {sh_out[31], sh_out == 32'd0, sh_c, flags[0]};
    end
  end

  // retire into state and output register
  always_ff @(posedge clk) begin
    if (fire) begin
      writes_register <= wr;
      dest_index      <= wr ? rd : 3'd0;
      written_value   <= wr ? value : 32'd0;
      flags_nzcv      <= nf;
      unsupported     <= bad;
    end
    if (rst) begin
      valid <= 1'b0;
      flags <= '0;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
    end else begin
      if (fire) valid <= 1'b1;
      else if (ready) valid <= 1'b0;
      if (fire && !bad) begin
        flags <= nf;
        if (wr) regs[rd] <= value;
      end
    end
  end
endmodule

FILE: src/thumb_alu_execute.sv
// Thumb ALU execute block, formats 1 to 4 (shift immediate, add/sub,
// immediate MOV/CMP/ADD/SUB, register ALU ops) over r0-r7 and NZCV.
// Input channel: valid/ready with a 16-bit instruction per beat.
// Output channel: valid/ready with write-back and new flags per beat.
// A front decoder classifies each instruction into a two-entry queue;
// the back end executes it and registers the result.
// Throughput: one instruction per cycle while out_ready stays high,
// through a combinational execute path (adder, barrel shifter,
// 32x32 multiplier low half).
// Reset clears the register file, flags, the decode queue and the
// result valid bit; the result payload itself is not reset.
// When the receiver stalls the result register holds, the queue fills,
// and ready falls once both queue entries are occupied.
// Unsupported formats produce a result with unsupported set.
module thumb_alu_execute #(
  parameter int unsigned QueueDepth = tae_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        writes_register,
  output logic [2:0]  dest_index,
  output logic [31:0] written_value,
  output logic [3:0]  flags_nzcv,
  output logic        unsupported
);
  import tae_pkg::*;

  logic q_valid, q_ready;
  dec_t q_data;

  tae_front #(.QueueDepth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .instruction(instruction), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  tae_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .valid(out_valid), .ready(out_ready), .writes_register(writes_register),
    .dest_index(dest_index), .written_value(written_value),
    .flags_nzcv(flags_nzcv), .unsupported(unsupported)
  );
endmodule

FILE: src/tae_checker.sv
`include "thumb_alu_execute_macros.svh"
module tae_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        writes_register,
  input logic [2:0]  dest_index,
  input logic [31:0] written_value,
  input logic        unsupported
);
  // unsupported beats never write
  `TAE_ASSERT_IMP(a_bad_nowrite, out_valid && unsupported, !writes_register)
  // no write means zero payload
  `TAE_ASSERT_IMP(a_zero_payload, out_valid && !writes_register, dest_index == 3'd0 && written_value == 32'd0)
  // a stalled result stays valid
  `TAE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
  // an accepted input shows a result after the queue slot and the result register
  `TAE_ASSERT_NEXT(a_flow, in_valid && in_ready, ##1 out_valid)
endmodule

bind thumb_alu_execute tae_checker u_tae_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .writes_register(writes_register),
  .dest_index(dest_index), .written_value(written_value), .unsupported(unsupported)
);

FILE: tb/tb_top.sv
module tb_top;
  import tae_pkg::*;

  localparam int unsigned StallLimit = 4000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] instruction;
  logic        out_valid;
  logic        out_ready;
  logic        writes_register;
  logic [2:0]  dest_index;
  logic [31:0] written_value;
  logic [3:0]  flags_nzcv;
  logic        unsupported;

  typedef struct packed {
    logic        wr;
    logic [2:0]  rd;
    logic [31:0] value;
    logic [3:0]  nzcv;
    logic        bad;
  } retire_t;

  logic [15:0] pending_ins[$];
  retire_t     expected_retire[$];
  logic [31:0] shadow_regs[8];
  logic [3:0]  shadow_nzcv;
  int          error_count;
  int          idle_cycles;
  bit          quiet_phase;
  bit          hold_off_req;
  int          send_gap;
  int          recv_gap;

  thumb_alu_execute dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
    .out_valid(out_valid), .out_ready(out_ready),
    .writes_register(writes_register), .dest_index(dest_index),
    .written_value(written_value), .flags_nzcv(flags_nzcv),
    .unsupported(unsupported)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [3:0] nz_flags(logic [31:0] v);
    return {v[31], v == 32'd0, 2'b00};
  endfunction

  // a + b + cin with all four flags
  function automatic logic [31:0] add_with_flags(logic [31:0] a, logic [31:0] b,
                                                 logic cin, output logic [3:0] f);
    logic [32:0] wide;
    logic [31:0] r;
    wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    r = wide[31:0];
    f = nz_flags(r);
    f[1] = wide[32];
    f[0] = (a[31] ^ r[31]) & (b[31] ^ r[31]);
    return r;
  endfunction

  // barrel shifter; carry left alone when the amount is zero
  function automatic logic [31:0] barrel(logic [1:0] kind, logic [31:0] v,
                                         logic [8:0] amount, inout logic c);
    logic [4:0] n;
    if (amount == 0) return v;
    case (kind)
      SH_LSL: begin
        if (amount < 32) begin
          c = v[32 - amount];
          return v << amount;
        end
        c = (amount == 32) ? v[0] : 1'b0;
        return 32'd0;
      end
      SH_LSR: begin
        if (amount < 32) begin
          c = v[amount - 1];
          return v >> amount;
        end
        c = (amount == 32) ? v[31] : 1'b0;
        return 32'd0;
      end
      SH_ASR: begin
        if (amount < 32) begin
          c = v[amount - 1];
          return $signed(v) >>> amount;
        end
        c = v[31];
        return {32{v[31]}};
      end
      default: begin
        n = amount[4:0];
        if (n == 0) begin
          c = v[31];
          return v;
        end
        c = v[n - 1];
        return (v >> n) | (v << (32 - n));
      end
    endcase
  endfunction

  // execute one instruction on the shadow state and return its retire record
  function automatic retire_t execute_thumb(logic [15:0] ins);
    retire_t     res;
    logic [3:0]  f;
    logic [3:0]  op;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    logic [31:0] imm;
    logic [8:0]  amt;
    logic        c;
    logic        wr;
    f = shadow_nzcv;
    c = f[1];
    rd = ins[2:0];
    rs = ins[5:3];
    v = 32'd0;
    wr = 1'b0;
    res = '0;
    if (ins[15:11] == 5'b00011) begin
      b = ins[10] ? {29'd0, ins[8:6]} : shadow_regs[ins[8:6]];
      a = shadow_regs[rs];
      if (ins[9]) v = add_with_flags(a, ~b, 1'b1, f);
      else v = add_with_flags(a, b, 1'b0, f);
      wr = 1'b1;
    end else if (ins[15:13] == 3'b000) begin
      amt = {4'd0, ins[10:6]};
      if (ins[12:11] != SH_LSL && amt == 0) amt = 9'd32;
      v = barrel(ins[12:11], shadow_regs[rs], amt, c);
      f = nz_flags(v) | {2'b00, c, f[0]};
      wr = 1'b1;
    end else if (ins[15:13] == 3'b001) begin
      imm = {24'd0, ins[7:0]};
      rd = ins[10:8];
      case (ins[12:11])
        IM_MOV: begin
          v = imm;
          f = {1'b0, imm == 0, f[1:0]};
          wr = 1'b1;
        end
        IM_ADD: begin
          v = add_with_flags(shadow_regs[rd], imm, 1'b0, f);
          wr = 1'b1;
        end
        default: begin
          v = add_with_flags(shadow_regs[rd], ~imm, 1'b1, f);
          wr = ins[12:11] == IM_SUB;
        end
      endcase
    end else if (ins[15:10] == 6'b010000) begin
      op = ins[9:6];
      a = shadow_regs[rd];
      b = shadow_regs[rs];
      wr = 1'b1;
      case (op)
        OP_AND: begin v = a & b; f = nz_flags(v) | {2'b00, f[1:0]}; end
        OP_EOR: begin v = a ^ b; f = nz_flags(v) | {2'b00, f[1:0]}; end
        OP_LSL: v = barrel(SH_LSL, a, {1'b0, b[7:0]}, c);
        OP_LSR: v = barrel(SH_LSR, a, {1'b0, b[7:0]}, c);
        OP_ASR: v = barrel(SH_ASR, a, {1'b0, b[7:0]}, c);
        OP_ADC: v = add_with_flags(a, b, f[1], f);
        OP_SBC: v = add_with_flags(a, ~b, f[1], f);
        OP_ROR: v = barrel(SH_ROR, a, {1'b0, b[7:0]}, c);
        OP_TST: begin f = nz_flags(a & b) | {2'b00, f[1:0]}; wr = 1'b0; end
        OP_NEG: v = add_with_flags(32'd0, ~b, 1'b1, f);
        OP_CMP: begin void'(add_with_flags(a, ~b, 1'b1, f)); wr = 1'b0; end
        OP_CMN: begin void'(add_with_flags(a, b, 1'b0, f)); wr = 1'b0; end
        OP_ORR: begin v = a | b; f = nz_flags(v) | {2'b00, f[1:0]}; end
        OP_MUL: begin v = a * b; f = nz_flags(v) | {3'b000, f[0]}; end
        OP_BIC: begin v = a & ~b; f = nz_flags(v) | {2'b00, f[1:0]}; end
        default: begin v = ~b; f = nz_flags(v) | {2'b00, f[1:0]}; end
      endcase
      if (op == OP_LSL || op == OP_LSR || op == OP_ASR || op == OP_ROR)
        f = nz_flags(v) | {2'b00, c, f[0]};
    end else begin
      res.bad = 1'b1;
      res.nzcv = shadow_nzcv;
      return res;
    end
    shadow_nzcv = f;
    if (wr) shadow_regs[rd] = v;
    res.wr = wr;
    res.rd = wr ? rd : 3'd0;
    res.value = wr ? v : 32'd0;
    res.nzcv = f;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // random register ALU / format 1-4 word, with a bias toward supported ones
  function automatic logic [15:0] random_ins();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: return {3'b000, 13'($urandom)};
      2: return {5'b00011, 11'($urandom)};
      3, 4: return {3'b001, 13'($urandom)};
      5, 6, 7: return {6'b010000, 10'($urandom)};
      8: return {3'b001, IM_MOV, 3'($urandom), 8'($urandom_range(0, 40))};
      default: return 16'($urandom);
    endcase
  endfunction

  // drive the instruction beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      instruction <= 16'd0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ins.size() > 0 &&
                   (quiet_phase || $urandom_range(0, 9) != 0)) begin
        instruction <= pending_ins.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (!quiet_phase && pending_ins.size() > 0) send_gap <= $urandom_range(1, 14) - 1;
      end
    end
  end

  // predict on accepted beats
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) expected_retire.push_back(execute_thumb(instruction));
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else if (hold_off_req) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (quiet_phase || $urandom_range(0, 9) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      recv_gap <= $urandom_range(1, 14) - 1;
    end
  end

  // check result beats against the oldest prediction
  always @(posedge clk) begin
    retire_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_retire.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, 32'd0);
      end else begin
        want = expected_retire.pop_front();
        if (writes_register !== want.wr)
          report_mismatch("writes_register", 32'(writes_register), 32'(want.wr));
        if (dest_index !== want.rd)
          report_mismatch("dest_index", 32'(dest_index), 32'(want.rd));
        if (written_value !== want.value)
          report_mismatch("written_value", written_value, want.value);
        if (flags_nzcv !== want.nzcv)
          report_mismatch("flags_nzcv", 32'(flags_nzcv), 32'(want.nzcv));
        if (unsupported !== want.bad)
          report_mismatch("unsupported", 32'(unsupported), 32'(want.bad));
      end
    end
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int k;
    rst = 1'b1;
    error_count = 0;
    quiet_phase = 1'b0;
    hold_off_req = 1'b0;
    for (k = 0; k < 8; k++) shadow_regs[k] = 32'd0;
    shadow_nzcv = 4'd0;
    // directed: load operands, then extremes and each special case
    pending_ins.push_back({5'b00100, 3'd0, 8'hFF});          // MOV r0,#255
    pending_ins.push_back({5'b00100, 3'd1, 8'h00});          // MOV r1,#0 -> Z
    pending_ins.push_back({5'b00000, 5'd24, 3'd0, 3'd2});    // LSL r2,r0,#24
    pending_ins.push_back({5'b00000, 5'd0, 3'd2, 3'd3});     // LSL #0
    pending_ins.push_back({5'b00010, 5'd0, 3'd2, 3'd4});     // ASR #32
    pending_ins.push_back({5'b00001, 5'd0, 3'd2, 3'd5});     // LSR #32
    pending_ins.push_back({5'b00011, 2'b10, 3'd7, 3'd0, 3'd6}); // ADD r6,r0,#7
    pending_ins.push_back({5'b00011, 2'b11, 3'd7, 3'd1, 3'd6}); // SUB r6,r1,#7
    pending_ins.push_back({5'b00011, 2'b00, 3'd2, 3'd4, 3'd7}); // ADD r7,r4,r2
    pending_ins.push_back({5'b00011, 2'b01, 3'd4, 3'd2, 3'd7}); // SUB r7,r2,r4
    pending_ins.push_back({5'b00101, 3'd0, 8'hFF});          // CMP r0,#255
    pending_ins.push_back({5'b00110, 3'd4, 8'hFF});          // ADD r4,#255
    pending_ins.push_back({5'b00111, 3'd1, 8'h01});          // SUB r1,#1
    pending_ins.push_back({5'b00100, 3'd5, 8'd32});          // r5 = 32
    pending_ins.push_back({5'b00100, 3'd3, 8'd33});          // r3 = 33
    for (k = 0; k < 16; k++) pending_ins.push_back({6'b010000, 4'(k), 3'(k % 3 + 3), 3'd4});
    pending_ins.push_back({6'b010000, OP_ROR, 3'd5, 3'd2});  // ROR by 32
    pending_ins.push_back({6'b010000, OP_LSL, 3'd3, 3'd7});  // LSL by 33
    pending_ins.push_back(16'hFFFF);                          // unsupported
    pending_ins.push_back(16'h4400);                          // hi-register op
    for (k = 0; k < 1400; k++) pending_ins.push_back(random_ins());
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // long receiver hold-off so the input stalls
    repeat (100) @(posedge clk);
    hold_off_req <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off_req <= 1'b0;
    wait (pending_ins.size() < 200);
    quiet_phase <= 1'b1;
    wait (pending_ins.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_retire.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
